>>> sv/scc_pkg.sv
// shared types and constants for the scc labeler
// no dependencies
`timescale 1ns / 1ps
package scc_pkg;
    localparam int MaxVertices = 64;
    localparam int VW = $clog2(MaxVertices);
    localparam int CW = VW + 1;

    localparam logic [1:0] OP_CLEAR    = 2'd0;
    localparam logic [1:0] OP_EDGE     = 2'd1;
    localparam logic [1:0] OP_RUN      = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE, S_ACLR, S_RCLR, S_ROOT, S_ROOT_RD, S_SCAN, S_NB_RD, S_NB_DO,
        S_CLOSE, S_POP_RD, S_POP_DO, S_POP_WR, S_ROOT_SET, S_PARENT,
        S_PAR_DO, S_EMIT, S_EMIT_DO
    } t_state;
endpackage

>>> sv/scc_labeler_rank_only_top.sv
// top level of the scc labeler: sequencer, rank memory and stacks
// depends on scc_pkg and scc_adj_mem
`timescale 1ns / 1ps
// usage:
//   a transaction is accepted when start is high and busy is low; fields are
//   i_op, i_src_vertex, i_dst_vertex. i_cfg_we/i_cfg_wdata load vertex_count,
//   only while busy is low.
//   op 0 sweeps the adjacency memory, one row per cycle, with busy high.
//   op 1 sets one edge by read-modify-write of its row.
//   op 2 clears ranks, runs the depth-first search, then emits one result
//   per vertex on o_valid; o_last marks the final one, which also carries
//   o_scc_count. reset runs the adjacency clear sweep (busy high), and sets
//   vertex_count to 64. results cannot be stalled: o_valid lasts one cycle.
module scc_labeler_rank_only_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_op,
    input  logic [5:0] i_src_vertex,
    input  logic [5:0] i_dst_vertex,
    input  logic       i_cfg_we,
    input  logic [6:0] i_cfg_wdata,
    output logic       o_valid,
    output logic [5:0] o_vertex,
    output logic [5:0] o_component,
    output logic [6:0] o_scc_count,
    output logic       o_last
);
    localparam int VW = scc_pkg::VW;
    localparam int CW = scc_pkg::CW;
    localparam int MV = scc_pkg::MaxVertices;

    scc_pkg::t_state r_state, n_state;
    logic [6:0]    r_vcount;
    logic [CW-1:0] r_n;
    logic [VW-1:0] r_src, r_dst;
    logic          r_edge;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_root, n_root;
    logic [CW-1:0] r_fd, n_fd;
    logic [CW-1:0] r_cd, n_cd;
    logic [CW-1:0] r_nrank, n_nrank;
    logic [CW-1:0] r_ncid, n_ncid;
    logic [CW-1:0] r_total, n_total;
    logic [VW-1:0] r_v, n_v;
    logic [CW-1:0] r_w, n_w;
    logic [CW-1:0] r_rv, n_rv;
    logic [VW-1:0] r_tv, n_tv;
    logic [CW-1:0] r_tn, n_tn;
    logic          r_tr, n_tr;

    // rank memory
    logic [CW-1:0] rank_mem [MV];
    logic          rk_we;
    logic [VW-1:0] rk_addr;
    logic [CW-1:0] rk_wd, rk_rd;
    always_ff @(posedge i_clk) begin
        if (rk_we) begin
            rank_mem[rk_addr] <= rk_wd;
        end
        rk_rd <= rank_mem[rk_addr];
    end

    // frame stack: top frame in registers, lower frames in memory
    logic [VW+CW:0] fr_mem [MV];
    logic           fr_we;
    logic [VW-1:0]  fr_raddr;
    logic [VW+CW:0] fr_wd, fr_rd;
    logic [VW-1:0]  top_i, par_i;
    assign top_i = VW'(r_fd - 1'b1);
    assign par_i = VW'(r_fd - 2'd2);
    assign fr_wd = {r_tv, r_tn, r_tr};
    always_ff @(posedge i_clk) begin
        if (fr_we) begin
            fr_mem[top_i] <= fr_wd;
        end
        fr_rd <= fr_mem[fr_raddr];
    end

    // component stack memory
    logic [VW-1:0] cs_mem [MV];
    logic          cs_we;
    logic [VW-1:0] cs_addr, cs_rd;
    always_ff @(posedge i_clk) begin
        if (cs_we) begin
            cs_mem[cs_addr] <= r_v;
        end
        cs_rd <= cs_mem[cs_addr];
    end

    // adjacency
    logic          adj_we;
    logic [VW-1:0] adj_waddr, adj_raddr;
    logic [MV-1:0] adj_wdata, adj_rd;
    scc_adj_mem u_adj (
        .i_clk  (i_clk),
        .i_we   (adj_we),
        .i_waddr(adj_waddr),
        .i_wdata(adj_wdata),
        .i_raddr(adj_raddr),
        .o_rdata(adj_rd)
    );

    // next set neighbour at or after r_w below r_n
    logic [MV-1:0] mask;
    logic          nb_found;
    logic [VW-1:0] nb_idx;
    always_comb begin
        for (int i = 0; i < MV; i++) begin
            mask[i] = adj_rd[i] && (CW'(i) >= r_w) && (CW'(i) < r_n);
        end
        nb_found = |mask;
        nb_idx   = '0;
        for (int i = MV - 1; i >= 0; i--) begin
            if (mask[i]) begin
                nb_idx = VW'(i);
            end
        end
    end

    logic [CW-1:0] act_n;
    always_comb begin
        if (r_vcount == 7'd0) begin
            act_n = CW'(1);
        end else if (CW'(r_vcount) > CW'(MV) || 7'(r_vcount) > 7'(MV)) begin
            act_n = CW'(MV);
        end else begin
            act_n = CW'(r_vcount);
        end
    end

    assign busy = (r_state != scc_pkg::S_IDLE);
    logic accept;
    assign accept = start && !busy;

    always_comb begin
        n_state = r_state; n_idx = r_idx; n_root = r_root; n_fd = r_fd;
        n_cd = r_cd; n_nrank = r_nrank; n_ncid = r_ncid; n_total = r_total;
        n_v = r_v; n_w = r_w; n_rv = r_rv;
        n_tv = r_tv; n_tn = r_tn; n_tr = r_tr;
        rk_we = 1'b0; rk_addr = r_v; rk_wd = '0;
        fr_we = 1'b0; fr_raddr = top_i;
        cs_we = 1'b0; cs_addr = VW'(r_cd);
        adj_we = 1'b0; adj_waddr = r_src; adj_wdata = '0; adj_raddr = r_v;
        o_valid = 1'b0; o_vertex = '0; o_component = '0; o_scc_count = '0;
        o_last = 1'b0;
        case (r_state)
            scc_pkg::S_IDLE: begin
                adj_raddr = i_src_vertex;
                if (accept) begin
                    n_idx = '0;
                    case (i_op)
                        scc_pkg::OP_CLEAR: n_state = scc_pkg::S_ACLR;
                        scc_pkg::OP_EDGE:  n_state = scc_pkg::S_ACLR;
                        scc_pkg::OP_RUN:   n_state = scc_pkg::S_RCLR;
                        default:           n_state = scc_pkg::S_IDLE;
                    endcase
                end
            end
            scc_pkg::S_ACLR: begin
                adj_we = 1'b1;
                if (r_edge) begin
                    adj_wdata = adj_rd | (MV'(1) << r_dst);
                    n_state = scc_pkg::S_IDLE;
                end else begin
                    adj_waddr = VW'(r_idx);
                    n_idx = r_idx + 1'b1;
                    if (r_idx == CW'(MV - 1)) begin
                        n_state = scc_pkg::S_IDLE;
                    end
                end
            end
            scc_pkg::S_RCLR: begin
                rk_we = 1'b1; rk_addr = VW'(r_idx);
                n_idx = r_idx + 1'b1;
                if (r_idx == r_n - 1'b1) begin
                    n_state = scc_pkg::S_ROOT; n_root = '0; n_fd = '0;
                    n_cd = '0; n_nrank = CW'(1); n_ncid = r_n - 1'b1;
                    n_total = '0;
                end
            end
            scc_pkg::S_ROOT: begin
                if (r_root == r_n) begin
                    n_state = scc_pkg::S_EMIT; n_idx = '0;
                end else begin
                    rk_addr = VW'(r_root);
                    n_state = scc_pkg::S_ROOT_RD;
                end
            end
            scc_pkg::S_ROOT_RD: begin
                n_root = r_root + 1'b1;
                if (rk_rd != '0) begin
                    n_state = scc_pkg::S_ROOT;
                end else begin
                    rk_we = 1'b1; rk_addr = VW'(r_root); rk_wd = r_nrank;
                    n_nrank = r_nrank + 1'b1;
                    fr_we = (r_fd != '0);
                    n_tv = VW'(r_root); n_tn = '0; n_tr = 1'b1;
                    n_fd = r_fd + 1'b1;
                    n_state = scc_pkg::S_SCAN;
                end
            end
            scc_pkg::S_SCAN: begin
                // read top vertex row and rank
                n_v = r_tv; n_w = r_tn;
                adj_raddr = r_tv; rk_addr = r_tv;
                n_state = scc_pkg::S_NB_RD;
            end
            scc_pkg::S_NB_RD: begin
                n_rv = rk_rd;
                if (!nb_found) begin
                    n_state = scc_pkg::S_CLOSE;
                end else begin
                    n_tn = CW'(nb_idx) + 1'b1;
                    n_w = CW'(nb_idx);
                    rk_addr = nb_idx;
                    n_state = scc_pkg::S_NB_DO;
                end
            end
            scc_pkg::S_NB_DO: begin
                if (rk_rd == '0 && r_fd < CW'(MV)) begin
                    rk_we = 1'b1; rk_addr = VW'(r_w); rk_wd = r_nrank;
                    n_nrank = r_nrank + 1'b1;
                    fr_we = 1'b1;
                    n_tv = VW'(r_w); n_tn = '0; n_tr = 1'b1;
                    n_fd = r_fd + 1'b1;
                end else if (rk_rd < r_rv) begin
                    rk_we = 1'b1; rk_addr = r_v; rk_wd = rk_rd;
                    n_tr = 1'b0;
                end
                n_state = scc_pkg::S_SCAN;
            end
            scc_pkg::S_CLOSE: begin
                n_fd = r_fd - 1'b1;
                fr_raddr = par_i;
                if (r_tr) begin
                    n_nrank = r_nrank - 1'b1;
                    n_state = scc_pkg::S_POP_RD;
                    cs_addr = VW'(r_cd - 1'b1);
                end else begin
                    if (r_cd < CW'(MV)) begin
                        cs_we = 1'b1; n_cd = r_cd + 1'b1;
                    end
                    n_state = scc_pkg::S_PARENT;
                end
            end
            scc_pkg::S_POP_RD: begin
                // cs_rd holds top vertex of component stack
                cs_addr = VW'(r_cd - 1'b1);
                if (r_cd == '0) begin
                    n_state = scc_pkg::S_ROOT_SET;
                end else begin
                    rk_addr = cs_rd;
                    n_state = scc_pkg::S_POP_DO;
                end
            end
            scc_pkg::S_POP_DO: begin
                if (r_rv <= rk_rd) begin
                    rk_we = 1'b1; rk_addr = cs_rd; rk_wd = r_ncid;
                    n_cd = r_cd - 1'b1; n_nrank = r_nrank - 1'b1;
                    cs_addr = VW'(r_cd - 2'd2);
                    n_state = scc_pkg::S_POP_WR;
                end else begin
                    n_state = scc_pkg::S_ROOT_SET;
                end
            end
            scc_pkg::S_POP_WR: begin
                cs_addr = VW'(r_cd - 1'b1);
                n_state = scc_pkg::S_POP_RD;
            end
            scc_pkg::S_ROOT_SET: begin
                rk_we = 1'b1; rk_wd = r_ncid; n_rv = r_ncid;
                n_ncid = r_ncid - 1'b1; n_total = r_total + 1'b1;
                n_state = scc_pkg::S_PARENT;
            end
            scc_pkg::S_PARENT: begin
                if (r_fd == '0) begin
                    n_state = scc_pkg::S_ROOT;
                end else begin
                    // parent frame back into the top registers
                    n_tv = fr_rd[VW+CW:CW+1];
                    n_tn = fr_rd[CW:1];
                    n_tr = fr_rd[0];
                    rk_addr = fr_rd[VW+CW:CW+1];
                    n_state = scc_pkg::S_PAR_DO;
                end
            end
            scc_pkg::S_PAR_DO: begin
                if (r_rv < rk_rd) begin
                    rk_we = 1'b1; rk_addr = r_tv; rk_wd = r_rv;
                    n_tr = 1'b0;
                end
                n_state = scc_pkg::S_SCAN;
            end
            scc_pkg::S_EMIT: begin
                rk_addr = VW'(r_idx);
                n_state = scc_pkg::S_EMIT_DO;
            end
            scc_pkg::S_EMIT_DO: begin
                o_valid = 1'b1; o_vertex = VW'(r_idx); o_component = rk_rd[5:0];
                n_idx = r_idx + 1'b1;
                if (r_idx == r_n - 1'b1) begin
                    o_last = 1'b1; o_scc_count = 7'(r_total);
                    n_state = scc_pkg::S_IDLE;
                end else begin
                    n_state = scc_pkg::S_EMIT;
                end
            end
            default: n_state = scc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scc_pkg::S_ACLR; r_vcount <= 7'(MV); r_edge <= 1'b0;
            r_idx <= '0; r_fd <= '0; r_cd <= '0; r_root <= '0;
            r_nrank <= CW'(1); r_ncid <= CW'(MV - 1); r_total <= '0;
        end else begin
            r_state <= n_state; r_idx <= n_idx; r_fd <= n_fd; r_cd <= n_cd;
            r_root <= n_root; r_nrank <= n_nrank; r_ncid <= n_ncid;
            r_total <= n_total;
            if (i_cfg_we && !busy) begin
                r_vcount <= i_cfg_wdata;
            end
            if (accept) begin
                r_edge <= (i_op == scc_pkg::OP_EDGE);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_v <= n_v; r_w <= n_w; r_rv <= n_rv;
        r_tv <= n_tv; r_tn <= n_tn; r_tr <= n_tr;
        if (accept) begin
            r_src <= i_src_vertex; r_dst <= i_dst_vertex; r_n <= act_n;
        end
    end

    a_fd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fd <= CW'(MV)) else $error("frame depth overflow");
    a_cd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cd <= CW'(MV)) else $error("component stack overflow");
    a_last_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> o_valid) else $error("last without valid");
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |=> !busy) else $error("busy after last result");
endmodule

>>> sv/scc_adj_mem.sv
// adjacency matrix memory, one row per vertex; whole-row write, registered read
// depends on scc_pkg
`timescale 1ns / 1ps
module scc_adj_mem (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [scc_pkg::VW-1:0]            i_waddr,
    input  logic [scc_pkg::MaxVertices-1:0]   i_wdata,
    input  logic [scc_pkg::VW-1:0]            i_raddr,
    output logic [scc_pkg::MaxVertices-1:0]   o_rdata
);
    logic [scc_pkg::MaxVertices-1:0] mem [scc_pkg::MaxVertices];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule
